// ===== sv/pts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, codes and field layout of the pump time budget scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int MAX_PUMPS   = 4;
  localparam int SLOT_W      = 2;
  localparam int KIND_W      = 4;
  localparam int IDX_W       = 8;
  localparam int MS_W        = 32;
  localparam int SEC_W       = 23;
  localparam int REG_COUNT   = 7;
  localparam int REG_IDX_W   = 3;
  localparam int STATUS_W    = 2;
  localparam int PROD_W      = 33;

  // Stream layout
  localparam int IN_TUSER_W  = 4;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam int IN_ELAPSED_LSB = 0;
  localparam int IN_IDX_LSB     = 32;
  localparam int IN_EMPTY_BIT   = 40;

  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_ACTIVE_BIT = 2;
  localparam int OUT_PUMP_LSB   = 3;
  localparam int OUT_REM_LSB    = 5;
  localparam int OUT_EMPTY_BIT  = 37;
  localparam int OUT_DUE_BIT    = 38;

  localparam logic [MS_W-1:0]   BUDGET_MAX = '1;
  localparam logic [9:0]        MS_PER_SEC = 10'd1000;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_TICK       = 4'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUE      = 4'd1;
  localparam logic [KIND_W-1:0] KIND_QUEUE_INF  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR_PUMP = 4'd3;
  localparam logic [KIND_W-1:0] KIND_SET_EMPTY  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR_ALL  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_REFRESH    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_POLL_RES   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_POLL_SOIL  = 4'd8;

  // Result status
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_IDX = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_UNUSED  = 2'd3;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_RES_RUN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RES_IDLE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SOIL     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CYCLE0   = 3'd3;

  localparam logic [SEC_W-1:0] RST_RES_RUN  = 23'd5;
  localparam logic [SEC_W-1:0] RST_RES_IDLE = 23'd60;
  localparam logic [SEC_W-1:0] RST_SOIL     = 23'd60;
  localparam logic [SEC_W-1:0] RST_CYCLE    = 23'd30;

  typedef struct packed {
    logic load_in;
    logic mult;
    logic apply;
    logic promote;
    logic load_out;
  } pts_cmd_t;

endpackage

// ===== sv/pts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: steps one request through multiply, apply, promote and output.
// ----------------------------------------------------------------------------
module pts_ctrl
  import pts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output pts_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_APPLY = 3'd2;
  localparam logic [2:0] ST_PROM  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mult  = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_PROM;
      end
      ST_PROM: begin
        cmd.promote = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/pts_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_dp
// Datapath: configuration registers, budgets, countdowns and result register.
// ----------------------------------------------------------------------------
module pts_dp
  import pts_pkg::*;
#(
  parameter int PUMPS = MAX_PUMPS
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  pts_cmd_t              cmd,
  input  logic [KIND_W-1:0]     kind,
  input  logic [MS_W-1:0]       elapsed_ms,
  input  logic [IDX_W-1:0]      pump_index,
  input  logic                  empty_flag,
  input  logic                  cfg_wr_en,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [SEC_W-1:0]      cfg_wdata,
  output logic [STATUS_W-1:0]   status,
  output logic                  pump_active,
  output logic [SLOT_W-1:0]     active_pump,
  output logic [MS_W-1:0]       active_remaining_ms,
  output logic                  reservoir_is_empty,
  output logic                  refresh_due
);

  localparam logic [IDX_W-1:0] PUMPS_IDX = IDX_W'(PUMPS);

  // configuration
  logic [SEC_W-1:0] cfg_r [REG_COUNT];

  // request latch
  logic [KIND_W-1:0] kind_r;
  logic [MS_W-1:0]   elapsed_r;
  logic [IDX_W-1:0]  idx_r;
  logic              empty_in_r;

  // scheduler state
  logic [MS_W-1:0]   budget_r [PUMPS];
  logic [MS_W-1:0]   budget_nxt [PUMPS];
  logic              active_r, active_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              empty_r, empty_nxt;
  logic [MS_W-1:0]   res_cd_r, res_cd_nxt;
  logic [MS_W-1:0]   soil_cd_r, soil_cd_nxt;

  // per-request scratch
  logic [MS_W-1:0]     add_r;
  logic                prom_r, prom_nxt;
  logic [STATUS_W-1:0] stat_r, stat_nxt;
  logic                due_r, due_nxt;

  logic                idx_ok;
  logic [SLOT_W-1:0]   idx_slot;
  logic [SEC_W-1:0]    sec_sel;
  logic [PROD_W-1:0]   prod;
  logic [MS_W-1:0]     act_budget;
  logic [MS_W-1:0]     idx_budget;
  logic [MS_W-1:0]     act_dec;
  logic [MS_W:0]       idx_sum;

  logic [MS_W-1:0]   rem_o_r;
  logic [STATUS_W-1:0] stat_o_r;
  logic              act_o_r, empty_o_r, due_o_r;
  logic [SLOT_W-1:0] pump_o_r;

  function automatic logic [MS_W-1:0] sat_sub(input logic [MS_W-1:0] v,
                                              input logic [MS_W-1:0] d);
    return (v <= d) ? '0 : v - d;
  endfunction

  assign idx_ok   = (idx_r < PUMPS_IDX);
  assign idx_slot = idx_r[SLOT_W-1:0];

  // read muxes over the pump slots
  always_comb begin
    act_budget = '0;
    idx_budget = '0;
    for (int p = 0; p < PUMPS; p++) begin
      if (slot_r == SLOT_W'(p)) act_budget = budget_r[p];
      if (idx_slot == SLOT_W'(p)) idx_budget = budget_r[p];
    end
  end

  assign act_dec = sat_sub(act_budget, elapsed_r);
  assign idx_sum = {1'b0, idx_budget} + {1'b0, add_r};

  // seconds operand of the conversion multiply
  always_comb begin
    case (kind_r)
      KIND_POLL_RES:  sec_sel = active_r ? cfg_r[REG_RES_RUN] : cfg_r[REG_RES_IDLE];
      KIND_POLL_SOIL: sec_sel = cfg_r[REG_SOIL];
      default:        sec_sel = cfg_r[REG_CYCLE0 + idx_slot];
    endcase
  end

  assign prod = PROD_W'(sec_sel) * PROD_W'(MS_PER_SEC);

  always_comb begin
    for (int p = 0; p < PUMPS; p++) budget_nxt[p] = budget_r[p];
    active_nxt  = active_r;
    slot_nxt    = slot_r;
    empty_nxt   = empty_r;
    res_cd_nxt  = res_cd_r;
    soil_cd_nxt = soil_cd_r;
    prom_nxt    = prom_r;
    stat_nxt    = stat_r;
    due_nxt     = due_r;

    if (cmd.apply) begin
      prom_nxt = 1'b0;
      stat_nxt = STATUS_OK;
      due_nxt  = 1'b0;
      case (kind_r)
        KIND_TICK: begin
          if (elapsed_r != '0) begin
            res_cd_nxt  = sat_sub(res_cd_r, elapsed_r);
            soil_cd_nxt = sat_sub(soil_cd_r, elapsed_r);
            if (active_r) begin
              for (int p = 0; p < PUMPS; p++)
                if (slot_r == SLOT_W'(p)) budget_nxt[p] = act_dec;
              if (act_dec == '0) active_nxt = 1'b0;
            end
            prom_nxt = 1'b1;
          end
        end
        KIND_QUEUE, KIND_QUEUE_INF: begin
          if (!idx_ok) begin
            stat_nxt = STATUS_BAD_IDX;
          end else if (empty_r) begin
            stat_nxt = STATUS_EMPTY;
          end else begin
            for (int p = 0; p < PUMPS; p++)
              if (idx_slot == SLOT_W'(p))
                budget_nxt[p] = idx_sum[MS_W] ? BUDGET_MAX : idx_sum[MS_W-1:0];
            prom_nxt = 1'b1;
          end
        end
        KIND_CLEAR_PUMP: begin
          if (!idx_ok) begin
            stat_nxt = STATUS_BAD_IDX;
          end else begin
            for (int p = 0; p < PUMPS; p++)
              if (idx_slot == SLOT_W'(p)) budget_nxt[p] = '0;
            if (active_r && slot_r == idx_slot) active_nxt = 1'b0;
            prom_nxt = 1'b1;
          end
        end
        KIND_SET_EMPTY: begin
          if (empty_in_r != empty_r) begin
            if (empty_in_r) begin
              for (int p = 0; p < PUMPS; p++) budget_nxt[p] = '0;
              active_nxt = 1'b0;
            end
            empty_nxt = empty_in_r;
          end
        end
        KIND_CLEAR_ALL: begin
          for (int p = 0; p < PUMPS; p++) budget_nxt[p] = '0;
          active_nxt = 1'b0;
        end
        KIND_REFRESH: begin
          res_cd_nxt  = '0;
          soil_cd_nxt = '0;
        end
        KIND_POLL_RES: begin
          if (res_cd_r == '0) begin
            due_nxt    = 1'b1;
            res_cd_nxt = add_r;
          end
        end
        KIND_POLL_SOIL: begin
          if (soil_cd_r == '0) begin
            due_nxt     = 1'b1;
            soil_cd_nxt = add_r;
          end
        end
        default: begin
        end
      endcase
    end

    // promote the lowest-index pump with budget left
    if (cmd.promote && prom_r && !active_r && !empty_r) begin
      for (int p = PUMPS - 1; p >= 0; p--) begin
        if (budget_r[p] != '0) begin
          active_nxt = 1'b1;
          slot_nxt   = SLOT_W'(p);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_RES_RUN]  <= RST_RES_RUN;
      cfg_r[REG_RES_IDLE] <= RST_RES_IDLE;
      cfg_r[REG_SOIL]     <= RST_SOIL;
      for (int r = int'(REG_CYCLE0); r < REG_COUNT; r++) cfg_r[r] <= RST_CYCLE;
      for (int p = 0; p < PUMPS; p++) budget_r[p] <= '0;
      active_r  <= 1'b0;
      slot_r    <= '0;
      empty_r   <= 1'b0;
      res_cd_r  <= '0;
      soil_cd_r <= '0;
      prom_r    <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index < REG_IDX_W'(REG_COUNT)) cfg_r[cfg_index] <= cfg_wdata;
      for (int p = 0; p < PUMPS; p++) budget_r[p] <= budget_nxt[p];
      active_r  <= active_nxt;
      slot_r    <= slot_nxt;
      empty_r   <= empty_nxt;
      res_cd_r  <= res_cd_nxt;
      soil_cd_r <= soil_cd_nxt;
      prom_r    <= prom_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
    due_r  <= due_nxt;
    if (cmd.load_in) begin
      kind_r     <= kind;
      elapsed_r  <= elapsed_ms;
      idx_r      <= pump_index;
      empty_in_r <= empty_flag;
    end
    if (cmd.mult) begin
      if (kind_r == KIND_QUEUE_INF) add_r <= BUDGET_MAX;
      else                          add_r <= prod[MS_W] ? BUDGET_MAX : prod[MS_W-1:0];
    end
    if (cmd.load_out) begin
      stat_o_r  <= stat_r;
      act_o_r   <= active_r;
      pump_o_r  <= active_r ? slot_r : '0;
      rem_o_r   <= active_r ? act_budget : '0;
      empty_o_r <= empty_r;
      due_o_r   <= due_r;
    end
  end

  assign status              = stat_o_r;
  assign pump_active         = act_o_r;
  assign active_pump         = pump_o_r;
  assign active_remaining_ms = rem_o_r;
  assign reservoir_is_empty  = empty_o_r;
  assign refresh_due         = due_o_r;

endmodule

// ===== sv/pump_time_budget_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_time_budget_scheduler
// Per-pump millisecond run budgets, one active pump at a time, and two
// sensor refresh countdowns.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Contents
//  --------+-----------+----------------------+--------------------------------
//  in_     | sink      | in_tvalid/in_tready  | one request (tick, queue, poll)
//  out_    | source    | out_tvalid/out_tready| one result per request
//  cfg_    | sink      | cfg_wr_en            | interval and cycle registers
//
// Every request steps through latch, seconds-to-ms multiply, apply,
// promotion of the next pump and output load. The sequencer handles one
// request at a time; the output register holds a finished result while the
// next request is taken. A stalled output holds the sequencer in its output
// step. Reset (rst_n low, synchronous) clears all budgets and countdowns,
// releases the active pump and loads the register defaults.
//
module pump_time_budget_scheduler
  import pts_pkg::*;
#(
  parameter int PUMPS = MAX_PUMPS
)(
  input  logic                   clk,
  input  logic                   rst_n,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // elapsed_ms[31:0], pump_index[39:32],
                                             // empty_flag[40], zero fill
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // kind[3:0]
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status[1:0], pump_active[2],
                                             // active_pump[4:3],
                                             // active_remaining_ms[36:5],
                                             // reservoir_is_empty[37],
                                             // refresh_due[38], zero fill
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [SEC_W-1:0]       cfg_wdata
);

  pts_cmd_t cmd;

  logic [STATUS_W-1:0] status;
  logic                pump_active;
  logic [SLOT_W-1:0]   active_pump;
  logic [MS_W-1:0]     active_remaining_ms;
  logic                reservoir_is_empty;
  logic                refresh_due;

  // sequencer: accept, step, and hand the result to the output register
  pts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // budgets, countdowns, configuration and result payload
  pts_dp #(
    .PUMPS (PUMPS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .kind                (in_tuser[KIND_W-1:0]),
    .elapsed_ms          (in_tdata[IN_ELAPSED_LSB +: MS_W]),
    .pump_index          (in_tdata[IN_IDX_LSB +: IDX_W]),
    .empty_flag          (in_tdata[IN_EMPTY_BIT]),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .status              (status),
    .pump_active         (pump_active),
    .active_pump         (active_pump),
    .active_remaining_ms (active_remaining_ms),
    .reservoir_is_empty  (reservoir_is_empty),
    .refresh_due         (refresh_due)
  );

  // pack the result, highest field first, status in the lowest bits
  assign out_tdata = {1'b0, refresh_due, reservoir_is_empty, active_remaining_ms,
                      active_pump, pump_active, status};

endmodule

// ===== sv/pts_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_chk
// Port-level checks of the pump time budget scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pts_chk
  import pts_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // drop any pending result on reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // one request at a time: no back-to-back accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while one is in progress");

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // no pump running means no slot and no budget shown
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[OUT_ACTIVE_BIT]) |->
      (out_tdata[OUT_EMPTY_BIT-1:OUT_PUMP_LSB] == '0))
    else $error("idle result shows a pump");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_STATUS_LSB +: STATUS_W] != STATUS_UNUSED))
    else $error("unused status code");

endmodule

bind pump_time_budget_scheduler pts_chk u_pts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/pump_time_budget_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_time_budget_scheduler_tb
// Self-checking regression for the pump time budget scheduler: a directed
// opening, then four register settings with random request traffic, checked
// against a cycle-free model of the budgets, promotion and sensor countdowns.
// ----------------------------------------------------------------------------
module pump_time_budget_scheduler_tb;
  import pts_pkg::*;

  localparam int PUMP_COUNT    = MAX_PUMPS;
  localparam int SETTLE_CYCLES = 12;     // extra wait once the queues are empty
  localparam int MAX_REPORTS   = 40;     // cap on printed mismatch lines
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [KIND_W-1:0]    KIND_TOP   = 4'd15;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [MS_W-1:0]   elapsed;
    logic [IDX_W-1:0]  idx;
    logic              empty_flag;
  } pump_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                pump_active;
    logic [SLOT_W-1:0]   active_pump;
    logic [MS_W-1:0]     remaining_ms;
    logic                tank_empty;
    logic                refresh_due;
  } pump_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [SEC_W-1:0] cfg_wdata = '0;

  // Scheduler state as the testbench sees it
  logic [MS_W-1:0]  run_budget [PUMP_COUNT];
  logic             pump_running;
  logic [SLOT_W-1:0] running_slot;
  logic             tank_empty;
  logic [MS_W-1:0]  tank_countdown;
  logic [MS_W-1:0]  soil_countdown;
  logic [SEC_W-1:0] interval_regs [REG_COUNT];

  pump_request_t pump_requests[$];      // requests waiting for the driver
  pump_report_t  scheduler_reports[$];  // expected results, oldest first

  logic        in_taken = 1'b0;
  int unsigned fail_count = 0;
  int unsigned requests_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned polls_due = 0;
  int unsigned index_errors = 0;
  int unsigned empty_refusals = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned sink_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 400;

  pump_time_budget_scheduler #(.PUMPS(PUMP_COUNT)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the scheduler
  // --------------------------------------------------------------------------

  // Subtract elapsed time, stopping at zero.
  function automatic logic [MS_W-1:0] drain_ms(logic [MS_W-1:0] v, logic [MS_W-1:0] d);
    return (v <= d) ? '0 : v - d;
  endfunction

  // Convert register seconds to milliseconds, clamping at the top of range.
  function automatic logic [MS_W-1:0] seconds_to_ms(logic [SEC_W-1:0] secs);
    logic [MS_W:0] ms;
    ms = secs * MS_PER_SEC;
    return ms[MS_W] ? BUDGET_MAX : ms[MS_W-1:0];
  endfunction

  // Promote the lowest pump with budget left when nothing runs.
  function automatic void promote_next();
    if (pump_running || tank_empty) return;
    for (int p = 0; p < PUMP_COUNT; p++) begin
      if (run_budget[p] != '0) begin
        pump_running = 1'b1;
        running_slot = SLOT_W'(p);
        return;
      end
    end
  endfunction

  function automatic void clear_budgets();
    foreach (run_budget[p]) run_budget[p] = '0;
    pump_running = 1'b0;
  endfunction

  function automatic void reset_schedule();
    clear_budgets();
    running_slot   = '0;
    tank_empty     = 1'b0;
    tank_countdown = '0;
    soil_countdown = '0;
    interval_regs[REG_RES_RUN]  = RST_RES_RUN;
    interval_regs[REG_RES_IDLE] = RST_RES_IDLE;
    interval_regs[REG_SOIL]     = RST_SOIL;
    for (int p = 0; p < PUMP_COUNT; p++)
      interval_regs[int'(REG_CYCLE0) + p] = RST_CYCLE;
  endfunction

  // Apply one request to the model and return the result it must produce.
  function automatic pump_report_t advance_schedule(pump_request_t r);
    pump_report_t   rep;
    logic [MS_W-1:0] add;
    logic [MS_W:0]   sum;
    rep = '0;
    rep.status = STATUS_OK;
    case (r.kind)
      KIND_TICK: begin
        if (r.elapsed != '0) begin
          tank_countdown = drain_ms(tank_countdown, r.elapsed);
          soil_countdown = drain_ms(soil_countdown, r.elapsed);
          if (pump_running) begin
            run_budget[running_slot] = drain_ms(run_budget[running_slot], r.elapsed);
            if (run_budget[running_slot] == '0) pump_running = 1'b0;
          end
          promote_next();
        end
      end
      KIND_QUEUE, KIND_QUEUE_INF: begin
        if (r.idx >= PUMP_COUNT) begin
          rep.status = STATUS_BAD_IDX;
        end else if (tank_empty) begin
          rep.status = STATUS_EMPTY;
        end else begin
          add = (r.kind == KIND_QUEUE) ?
                seconds_to_ms(interval_regs[int'(REG_CYCLE0) + int'(r.idx)]) : BUDGET_MAX;
          sum = {1'b0, run_budget[r.idx]} + add;
          run_budget[r.idx] = sum[MS_W] ? BUDGET_MAX : sum[MS_W-1:0];
          promote_next();
        end
      end
      KIND_CLEAR_PUMP: begin
        if (r.idx >= PUMP_COUNT) begin
          rep.status = STATUS_BAD_IDX;
        end else begin
          run_budget[r.idx] = '0;
          if (pump_running && running_slot == r.idx) pump_running = 1'b0;
          promote_next();
        end
      end
      KIND_SET_EMPTY: begin
        if (r.empty_flag != tank_empty) begin
          if (r.empty_flag) clear_budgets();
          tank_empty = r.empty_flag;
        end
      end
      KIND_CLEAR_ALL: clear_budgets();
      KIND_REFRESH: begin
        tank_countdown = '0;
        soil_countdown = '0;
      end
      KIND_POLL_RES: begin
        if (tank_countdown == '0) begin
          rep.refresh_due = 1'b1;
          tank_countdown = seconds_to_ms(pump_running ? interval_regs[REG_RES_RUN]
                                                      : interval_regs[REG_RES_IDLE]);
        end
      end
      KIND_POLL_SOIL: begin
        if (soil_countdown == '0) begin
          rep.refresh_due = 1'b1;
          soil_countdown = seconds_to_ms(interval_regs[REG_SOIL]);
        end
      end
      default: ;
    endcase
    rep.pump_active  = pump_running;
    rep.active_pump  = pump_running ? running_slot : '0;
    rep.remaining_ms = pump_running ? run_budget[running_slot] : '0;
    rep.tank_empty   = tank_empty;
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic add_request(logic [KIND_W-1:0] kind, logic [MS_W-1:0] elapsed,
                             logic [IDX_W-1:0] idx, logic empty_flag);
    pump_request_t r;
    r.kind       = kind;
    r.elapsed    = elapsed;
    r.idx        = idx;
    r.empty_flag = empty_flag;
    pump_requests.push_back(r);
  endtask

  // Draw a request: mostly ticks, queues and polls on real pumps, with some
  // out-of-range indexes, unknown kinds and extreme elapsed times mixed in.
  function automatic pump_request_t random_request(int unsigned elapsed_span);
    pump_request_t r;
    int unsigned   pick;
    r.kind       = KIND_W'($urandom);
    r.elapsed    = $urandom;
    r.idx        = IDX_W'($urandom);
    r.empty_flag = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 36)      r.kind = KIND_TICK;
    else if (pick < 56) r.kind = KIND_QUEUE;
    else if (pick < 59) r.kind = KIND_QUEUE_INF;
    else if (pick < 66) r.kind = KIND_CLEAR_PUMP;
    else if (pick < 72) r.kind = KIND_SET_EMPTY;
    else if (pick < 74) r.kind = KIND_CLEAR_ALL;
    else if (pick < 77) r.kind = KIND_REFRESH;
    else if (pick < 86) r.kind = KIND_POLL_RES;
    else if (pick < 95) r.kind = KIND_POLL_SOIL;
    else                r.kind = KIND_W'($urandom_range(KIND_POLL_SOIL + 1, KIND_TOP));
    if ($urandom_range(0, 9) != 0) r.idx = IDX_W'($urandom_range(0, PUMP_COUNT - 1));
    pick = $urandom_range(0, 19);
    if (pick == 0)      r.elapsed = '0;
    else if (pick == 1) r.elapsed = BUDGET_MAX;
    else if (pick > 3)  r.elapsed = $urandom_range(1, elapsed_span);
    // Leaving the empty state should be more likely than entering it.
    if (r.kind == KIND_SET_EMPTY && $urandom_range(0, 2) != 0) r.empty_flag = 1'b0;
    return r;
  endfunction

  task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [SEC_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every request is taken and every result has come back.
  task automatic wait_until_idle();
    while (pump_requests.size() != 0 || in_tvalid || scheduler_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string field, logic [MS_W-1:0] want, logic [MS_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps. Hold a
  // request steady until it is taken; advance only on an accepted handshake.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : request_driver
    logic next_valid;
    pump_request_t head;
    next_valid = in_tvalid;
    if (in_taken) begin
      void'(pump_requests.pop_front());
      next_valid = 1'b0;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
    if (!next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pump_requests.size() != 0) begin
        head = pump_requests[0];
        next_valid = 1'b1;
        in_tuser <= head.kind;
        in_tdata <= {{(IN_TDATA_W - IN_EMPTY_BIT - 1){1'b0}},
                     head.empty_flag, head.idx, head.elapsed};
      end
    end
    in_tvalid <= next_valid;
  end

  // --------------------------------------------------------------------------
  // Result sink: cycle through always-ready, mostly-ready, mostly-stalled and
  // periodic patterns. Twice in the run, hold off for a long stretch so the
  // block backs up and stalls its request side.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : report_sink
    logic ready;
    sink_cycle++;
    if (hold_left == 0 && reports_seen >= next_hold_at) begin
      hold_left    = 300;
      next_hold_at = next_hold_at + 800;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready = 1'b0;
    end else begin
      case ((sink_cycle / 113) % 4)
        0:       ready = 1'b1;
        1:       ready = ($urandom_range(0, 3) != 0);
        2:       ready = ($urandom_range(0, 3) == 0);
        default: ready = (sink_cycle % 3 != 0);
      endcase
    end
    out_tready <= ready;
  end

  // --------------------------------------------------------------------------
  // Monitor: track register writes, predict each accepted request from the
  // pins, and compare each accepted result against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : report_monitor
    pump_request_t req;
    pump_report_t  want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (cfg_wr_en && cfg_index < REG_COUNT)
        interval_regs[cfg_index] = cfg_wdata;
      if (in_tvalid && in_tready) begin
        req.kind       = in_tuser[KIND_W-1:0];
        req.elapsed    = in_tdata[IN_ELAPSED_LSB +: MS_W];
        req.idx        = in_tdata[IN_IDX_LSB +: IDX_W];
        req.empty_flag = in_tdata[IN_EMPTY_BIT];
        want = advance_schedule(req);
        requests_sent++;
        if (want.refresh_due) polls_due++;
        if (want.status == STATUS_BAD_IDX) index_errors++;
        if (want.status == STATUS_EMPTY) empty_refusals++;
        scheduler_reports.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (scheduler_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t ns: result with none expected, expected nothing actual 0x%0h",
                     $time, out_tdata);
        end else begin
          want = scheduler_reports.pop_front();
          check_field("status", MS_W'(want.status),
                      MS_W'(out_tdata[OUT_STATUS_LSB +: STATUS_W]));
          check_field("pump_active", MS_W'(want.pump_active),
                      MS_W'(out_tdata[OUT_ACTIVE_BIT]));
          check_field("active_pump", MS_W'(want.active_pump),
                      MS_W'(out_tdata[OUT_PUMP_LSB +: SLOT_W]));
          check_field("active_remaining_ms", want.remaining_ms,
                      out_tdata[OUT_REM_LSB +: MS_W]);
          check_field("reservoir_is_empty", MS_W'(want.tank_empty),
                      MS_W'(out_tdata[OUT_EMPTY_BIT]));
          check_field("refresh_due", MS_W'(want.refresh_due),
                      MS_W'(out_tdata[OUT_DUE_BIT]));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    int unsigned   phase_items;
    int unsigned   span;
    pump_request_t r;
    reset_schedule();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening with reset register values.
    add_request(KIND_POLL_RES, '0, '0, 1'b0);        // countdown starts at zero
    add_request(KIND_POLL_SOIL, '0, '0, 1'b0);
    add_request(KIND_POLL_RES, '0, '0, 1'b0);        // reloaded, not due
    add_request(KIND_TICK, '0, 8'hFF, 1'b1);         // zero tick changes nothing
    add_request(KIND_QUEUE, '0, 8'd0, 1'b0);
    add_request(KIND_QUEUE_INF, '0, 8'd3, 1'b0);
    add_request(KIND_QUEUE, '0, 8'hFF, 1'b0);        // index out of range
    add_request(KIND_CLEAR_PUMP, '0, 8'd4, 1'b0);    // first index out of range
    add_request(KIND_TICK, 32'd1000, '0, 1'b0);
    add_request(KIND_TICK, BUDGET_MAX, '0, 1'b0);    // release pump 0, promote 3
    add_request(KIND_QUEUE_INF, '0, 8'd3, 1'b0);     // add clamps at the top
    add_request(KIND_REFRESH, '0, '0, 1'b0);
    add_request(KIND_POLL_RES, '0, '0, 1'b0);        // reload with running interval
    add_request(KIND_TICK, 32'd4999, '0, 1'b0);
    add_request(KIND_POLL_RES, '0, '0, 1'b0);
    add_request(KIND_TICK, 32'd1, '0, 1'b0);
    add_request(KIND_POLL_RES, '0, '0, 1'b0);
    add_request(KIND_CLEAR_PUMP, '0, 8'd3, 1'b0);    // release the running pump
    add_request(KIND_QUEUE, '0, 8'd2, 1'b0);
    add_request(KIND_QUEUE, '0, 8'd1, 1'b0);
    add_request(KIND_SET_EMPTY, '0, '0, 1'b1);       // empty clears all budgets
    add_request(KIND_SET_EMPTY, '0, '0, 1'b1);       // same value again
    add_request(KIND_QUEUE, '0, 8'd2, 1'b0);         // refused while empty
    add_request(KIND_QUEUE_INF, '0, 8'd200, 1'b0);   // bad index wins over empty
    add_request(KIND_SET_EMPTY, '0, '0, 1'b0);       // leave empty, no promotion
    add_request(KIND_CLEAR_ALL, '0, '0, 1'b0);
    add_request(KIND_W'(KIND_POLL_SOIL + 1), BUDGET_MAX, 8'hFF, 1'b1);  // unknown kinds
    add_request(KIND_TOP, '0, '0, 1'b0);
    wait_until_idle();

    // Four register settings: all zero, all at maximum, small random, full
    // random. The unused index is written too and must change nothing.
    for (int phase = 1; phase <= 4; phase++) begin
      for (int g = 0; g < REG_COUNT; g++) begin
        case (phase)
          1:       write_register(REG_IDX_W'(g), '0);
          2:       write_register(REG_IDX_W'(g), '1);
          3:       write_register(REG_IDX_W'(g), SEC_W'($urandom_range(1, 60)));
          default: write_register(REG_IDX_W'(g), SEC_W'($urandom));
        endcase
      end
      write_register(REG_UNUSED, SEC_W'($urandom));
      case (phase)
        1:       begin phase_items = 300; span = 20000; end
        2:       begin phase_items = 300; span = 32'hFFFF_FFFF; end
        3:       begin phase_items = 500; span = 30000; end
        default: begin phase_items = 400; span = 32'h4000_0000; end
      endcase
      for (int n = 0; n < phase_items; n++) begin
        r = random_request(span);
        pump_requests.push_back(r);
      end
      wait_until_idle();
    end

    $display("Ran %0d requests and checked %0d results over five register settings.",
             requests_sent, reports_seen);
    $display("Polls due: %0d, index errors: %0d, refusals while empty: %0d.",
             polls_due, index_errors, empty_refusals);
    if (fail_count == 0 && scheduler_reports.size() == 0) begin
      $display("pump_time_budget_scheduler regression: pass");
    end else begin
      $display("pump_time_budget_scheduler regression: fail");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal finish.
  initial begin : watchdog
    #5_000_000;
    $display("pump_time_budget_scheduler regression: fail");
    $finish;
  end

endmodule
